[hw/rtl/capacity_budget_edge_partitioner_core_macros.svh]
// Assertion macros for the capacity budget edge partitioner.
// Expect signals clk and rst_n in the scope of each use.
`ifndef CAPACITY_BUDGET_EDGE_PARTITIONER_CORE_MACROS_SVH
`define CAPACITY_BUDGET_EDGE_PARTITIONER_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CBEP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cbep: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define CBEP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbep: implication violated");

// Consequent holds in the cycle after the antecedent.
`define CBEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbep: sequence violated");

`endif

[hw/rtl/cbep_pkg.sv]
// Shared widths, register indexes and result type of the edge partitioner.
// No dependencies.
package cbep_pkg;

    localparam int VID_W   = 20;
    localparam int DEG_W   = 21;
    localparam int CAP_W   = 40;
    localparam int VTOT_W  = 21;
    localparam int PIDX_W  = 16;
    localparam int CNT_W   = 32;
    localparam int VCNT_W  = 21;
    localparam int PVERT_W = 22;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_TOTAL = 2'd1;

    // words charged per new endpoint (main / aux budget) and per edge
    localparam int VERT_WORDS_MAIN = 4;
    localparam int VERT_WORDS_AUX  = 1;
    localparam int EDGE_WORDS      = 2;

    localparam logic [VCNT_W-1:0] VCOUNT_MAX = '1;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [PIDX_W-1:0]  part_index;
        logic               opened_new;
        logic [CNT_W-1:0]   part_edges;
        logic [PVERT_W-1:0] part_vertices;
        logic [CNT_W-1:0]   part_first_edge;
        logic               run_done;
        logic               part_overflow;
    } result_t;

endpackage

[hw/rtl/cbep_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies; read during write to one address returns the old data.
module cbep_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/capacity_budget_edge_partitioner_core.sv]
// Capacity budget edge partitioner: packs a stream of edges into partitions.
// Depends on cbep_pkg, cbep_ram and the assertion macro header.
//
// An edge is not taken while the edge before it is in stage A: both endpoint
// tags are read through the single read port of the tag RAM, one per cycle. An
// edge's result passes stage A and stage B and leaves through a four-entry result
// queue; edges also stall when the queue entries and the edges ahead of it would
// overfill it. The tag RAM is cleared by a pass over all MAX_VERTICES addresses
// after reset and after every edge with last_edge set, during which edge_stall is
// high; configuration writes are taken at any time. Vertex ids address the RAM
// modulo MAX_VERTICES, which must be a power of two.
`include "capacity_budget_edge_partitioner_core_macros.svh"

module capacity_budget_edge_partitioner_core
    import cbep_pkg::*;
#(
    parameter int MAX_VERTICES = 1048576,
    parameter int TAG_BITS     = 16,
    parameter int ID_BYTES     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAP_W-1:0]     cfg_data,

    input  logic                 edge_valid,
    output logic                 edge_stall,
    input  logic [VID_W-1:0]     vertex_u,
    input  logic [VID_W-1:0]     vertex_v,
    input  logic [DEG_W-1:0]     degree_u,
    input  logic [DEG_W-1:0]     degree_v,
    input  logic                 last_edge,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [PIDX_W-1:0]    part_index,
    output logic                 opened_new,
    output logic [CNT_W-1:0]     part_edges,
    output logic [PVERT_W-1:0]   part_vertices,
    output logic [CNT_W-1:0]     part_first_edge,
    output logic                 run_done,
    output logic                 part_overflow
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int IDX_W  = (ADDR_W > VID_W) ? ADDR_W : VID_W;
    localparam int ID_W   = $clog2(ID_BYTES + 1);
    localparam int COST_W = DEG_W + 3 + ID_W + 1;
    localparam int USED_W = CAP_W + 1;
    localparam int RES_W  = VTOT_W + $clog2(2 * ID_BYTES + 1);

    localparam logic [TAG_BITS-1:0] MAX_PART = {{(TAG_BITS-1){1'b1}}, 1'b0};
    localparam logic [COST_W-1:0]   C_NONE   = COST_W'(EDGE_WORDS * ID_BYTES + 1);
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);

    // configuration and budgets
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [VTOT_W-1:0] vt_reg, vt_next;
    logic [CAP_W-1:0]  avail1_reg, avail1_next;
    logic [CAP_W-1:0]  avail2_reg, avail2_next;
    logic [RES_W-1:0]  res1, res2;

    // stage A: tag read of v issued
    logic              a_valid_reg, a_valid_next;
    logic [ADDR_W-1:0] a_u_reg, a_v_reg;
    logic [DEG_W-1:0]  a_du_reg, a_dv_reg;
    logic              a_last_reg;
    logic [IDX_W-1:0]  u_ext, v_ext;

    // stage B: decision
    logic                b_valid_reg, b_valid_next;
    logic [ADDR_W-1:0]   b_u_reg, b_v_reg;
    logic                b_same_reg, b_last_reg;
    logic [TAG_BITS-1:0] b_tu_reg;
    logic [COST_W-1:0]   b_c1_uv_reg, b_c1_u_reg, b_c1_v_reg;
    logic [COST_W-1:0]   b_c2_uv_reg, b_c2_u_reg, b_c2_v_reg;
    logic [COST_W-1:0]   c1_uv_next, c1_u_next, c1_v_next;
    logic [COST_W-1:0]   c2_uv_next, c2_u_next, c2_v_next;
    logic [COST_W-1:0]   du_ext, dv_ext;

    // forwarding of the previous edge's tag writes
    logic                fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]   fwd_u_reg, fwd_v_reg;
    logic [TAG_BITS-1:0] fwd_tag_reg;

    // second write of an edge, in the cycle after the decision
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [TAG_BITS-1:0] pend_tag_reg;

    // clearing pass
    logic              clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_go;
    logic              last_block_reg, last_block_next;

    // partition state
    logic [TAG_BITS-1:0] cur_reg, cur_next;
    logic [CAP_W-1:0]    used1_reg, used1_next;
    logic [CAP_W-1:0]    used2_reg, used2_next;
    logic [CNT_W-1:0]    edges_reg, edges_next;
    logic [VCNT_W-1:0]   verts_reg, verts_next;
    logic [CNT_W-1:0]    ectr_reg, ectr_next;
    logic [CNT_W-1:0]    first_reg, first_next;

    // decision datapath
    logic [TAG_BITS-1:0] tag_cur, tu_eff, tv_eff, tag_new;
    logic                mu, mv, fit, ovf;
    logic [COST_W-1:0]   c1, c2;
    logic [USED_W-1:0]   sum1, sum2;
    logic [1:0]          vinc;
    logic [PVERT_W-1:0]  vsum;
    logic [TAG_BITS-1:0] cur_upd;
    logic [CAP_W-1:0]    used1_upd, used2_upd;
    logic [CNT_W-1:0]    edges_upd, first_upd;
    logic [VCNT_W-1:0]   verts_upd;
    result_t             entry;

    // tag RAM ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [TAG_BITS-1:0] ram_wdata, ram_rdata;

    // result queue
    result_t              fifo_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next, occ;
    logic                 accept, push, pop;

    cbep_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;

    assign u_ext = IDX_W'(vertex_u);
    assign v_ext = IDX_W'(vertex_v);

    assign occ = count_reg + OUT_CNT_W'(a_valid_reg) + OUT_CNT_W'(b_valid_reg);
    assign edge_stall = clr_active_reg || last_block_reg || a_valid_reg
                        || (occ >= OUT_CNT_W'(OUT_DEPTH));
    assign accept = edge_valid && !edge_stall;
    assign push   = b_valid_reg;
    assign pop    = result_valid && !result_stall;

    assign result_valid    = (count_reg != '0);
    assign part_index      = fifo_mem_reg[head_reg].part_index;
    assign opened_new      = fifo_mem_reg[head_reg].opened_new;
    assign part_edges      = fifo_mem_reg[head_reg].part_edges;
    assign part_vertices   = fifo_mem_reg[head_reg].part_vertices;
    assign part_first_edge = fifo_mem_reg[head_reg].part_first_edge;
    assign run_done        = fifo_mem_reg[head_reg].run_done;
    assign part_overflow   = fifo_mem_reg[head_reg].part_overflow;

    always_comb
    begin
        cap_next = cap_reg;
        vt_next  = vt_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAPACITY:     cap_next = cfg_data;
                REG_VERTEX_TOTAL: vt_next  = cfg_data[VTOT_W-1:0];
                default:          ;
            endcase
        end
        res1 = RES_W'(vt_reg) * RES_W'(ID_BYTES);
        res2 = RES_W'(vt_reg) * RES_W'(2 * ID_BYTES);
        avail1_next = (cap_reg > CAP_W'(res1)) ? cap_reg - CAP_W'(res1) : '0;
        avail2_next = (cap_reg > CAP_W'(res2)) ? cap_reg - CAP_W'(res2) : '0;
    end

    // candidate costs, one per pattern of new endpoints
    always_comb
    begin
        du_ext = COST_W'(a_du_reg);
        dv_ext = COST_W'(a_dv_reg);
        c1_u_next  = (du_ext + COST_W'(VERT_WORDS_MAIN + EDGE_WORDS)) * COST_W'(ID_BYTES)
                     + COST_W'(1);
        c1_v_next  = (dv_ext + COST_W'(VERT_WORDS_MAIN + EDGE_WORDS)) * COST_W'(ID_BYTES)
                     + COST_W'(1);
        c1_uv_next = (du_ext + dv_ext + COST_W'(2 * VERT_WORDS_MAIN + EDGE_WORDS))
                     * COST_W'(ID_BYTES) + COST_W'(1);
        c2_u_next  = (du_ext + COST_W'(VERT_WORDS_AUX + EDGE_WORDS)) * COST_W'(ID_BYTES)
                     + COST_W'(1);
        c2_v_next  = (dv_ext + COST_W'(VERT_WORDS_AUX + EDGE_WORDS)) * COST_W'(ID_BYTES)
                     + COST_W'(1);
        c2_uv_next = (du_ext + dv_ext + COST_W'(2 * VERT_WORDS_AUX + EDGE_WORDS))
                     * COST_W'(ID_BYTES) + COST_W'(1);
    end

    // decision on the edge in stage B; v's tag arrives from the RAM this cycle
    always_comb
    begin
        tag_cur = cur_reg + TAG_BITS'(1);
        tu_eff  = (fwd_valid_reg && (b_u_reg == fwd_u_reg || b_u_reg == fwd_v_reg))
                  ? fwd_tag_reg : b_tu_reg;
        tv_eff  = (fwd_valid_reg && (b_v_reg == fwd_u_reg || b_v_reg == fwd_v_reg))
                  ? fwd_tag_reg : ram_rdata;
        mu = (tu_eff == tag_cur);
        mv = (tv_eff == tag_cur);
        case ({mu, mv})
            2'b00:   begin c1 = b_c1_uv_reg; c2 = b_c2_uv_reg; end
            2'b01:   begin c1 = b_c1_u_reg;  c2 = b_c2_u_reg;  end
            2'b10:   begin c1 = b_c1_v_reg;  c2 = b_c2_v_reg;  end
            default: begin c1 = C_NONE;      c2 = C_NONE;      end
        endcase
        sum1 = USED_W'(used1_reg) + USED_W'(c1);
        sum2 = USED_W'(used2_reg) + USED_W'(c2);
        fit  = (sum1 < USED_W'(avail1_reg)) && (sum2 < USED_W'(avail2_reg));

        vinc = 2'(!mu) + 2'(!mv && !b_same_reg);
        vsum = PVERT_W'(verts_reg) + PVERT_W'(vinc);

        ovf = 1'b0;
        if (fit)
        begin
            cur_upd   = cur_reg;
            used1_upd = sum1[CAP_W-1:0];
            used2_upd = sum2[CAP_W-1:0];
            edges_upd = edges_reg + CNT_W'(1);
            verts_upd = (vsum > PVERT_W'(VCOUNT_MAX)) ? VCOUNT_MAX : vsum[VCNT_W-1:0];
            first_upd = first_reg;
        end
        else
        begin
            // new partition: cost taken with both endpoints new
            if (cur_reg < MAX_PART)
            begin
                cur_upd = cur_reg + TAG_BITS'(1);
            end
            else
            begin
                cur_upd = cur_reg;
                ovf     = 1'b1;
            end
            used1_upd = CAP_W'(b_c1_uv_reg);
            used2_upd = CAP_W'(b_c2_uv_reg);
            edges_upd = CNT_W'(1);
            verts_upd = b_same_reg ? VCNT_W'(1) : VCNT_W'(2);
            first_upd = ectr_reg;
        end
        tag_new = cur_upd + TAG_BITS'(1);

        entry.part_index      = PIDX_W'(cur_upd);
        entry.opened_new      = !fit;
        entry.part_edges      = edges_upd;
        entry.part_vertices   = PVERT_W'(verts_upd);
        entry.part_first_edge = first_upd;
        entry.run_done        = b_last_reg;
        entry.part_overflow   = ovf;
    end

    always_comb
    begin
        a_valid_next    = accept;
        b_valid_next    = a_valid_reg;
        pend_valid_next = b_valid_reg;
        fwd_valid_next  = fwd_valid_reg;
        last_block_next = last_block_reg;
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        cur_next        = cur_reg;
        used1_next      = used1_reg;
        used2_next      = used2_reg;
        edges_next      = edges_reg;
        verts_next      = verts_reg;
        ectr_next       = ectr_reg;
        first_next      = first_reg;

        if (accept && last_edge)
        begin
            last_block_next = 1'b1;
        end

        clr_go = clr_active_reg && !pend_valid_reg;
        if (clr_go)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
        end

        if (b_valid_reg)
        begin
            if (b_last_reg)
            begin
                // end of run: state back to reset, tag RAM swept
                cur_next        = '0;
                used1_next      = '0;
                used2_next      = '0;
                edges_next      = '0;
                verts_next      = '0;
                ectr_next       = '0;
                first_next      = '0;
                fwd_valid_next  = 1'b0;
                last_block_next = 1'b0;
                clr_active_next = 1'b1;
                clr_cnt_next    = '0;
            end
            else
            begin
                cur_next       = cur_upd;
                used1_next     = used1_upd;
                used2_next     = used2_upd;
                edges_next     = edges_upd;
                verts_next     = verts_upd;
                ectr_next      = ectr_reg + CNT_W'(1);
                first_next     = first_upd;
                fwd_valid_next = 1'b1;
            end
        end

        // read port: u at transaction, v the cycle after
        ram_raddr = a_valid_reg ? a_v_reg : u_ext[ADDR_W-1:0];

        // write port: u at decision, v next cycle, sweep in the gaps
        if (b_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = b_u_reg;
            ram_wdata = tag_new;
        end
        else if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_tag_reg;
        end
        else
        begin
            ram_we    = clr_go;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end

        head_next  = pop ? head_reg + OUT_PTR_W'(1) : head_reg;
        tail_next  = push ? tail_reg + OUT_PTR_W'(1) : tail_reg;
        count_next = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= '0;
            vt_reg         <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            last_block_reg <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            cur_reg        <= '0;
            used1_reg      <= '0;
            used2_reg      <= '0;
            edges_reg      <= '0;
            verts_reg      <= '0;
            ectr_reg       <= '0;
            first_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            cap_reg        <= cap_next;
            vt_reg         <= vt_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            last_block_reg <= last_block_next;
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            cur_reg        <= cur_next;
            used1_reg      <= used1_next;
            used2_reg      <= used2_next;
            edges_reg      <= edges_next;
            verts_reg      <= verts_next;
            ectr_reg       <= ectr_next;
            first_reg      <= first_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avail1_reg <= avail1_next;
        avail2_reg <= avail2_next;
        if (accept)
        begin
            a_u_reg    <= u_ext[ADDR_W-1:0];
            a_v_reg    <= v_ext[ADDR_W-1:0];
            a_du_reg   <= degree_u;
            a_dv_reg   <= degree_v;
            a_last_reg <= last_edge;
        end
        if (a_valid_reg)
        begin
            b_u_reg     <= a_u_reg;
            b_v_reg     <= a_v_reg;
            b_same_reg  <= (a_u_reg == a_v_reg);
            b_last_reg  <= a_last_reg;
            b_tu_reg    <= ram_rdata;
            b_c1_uv_reg <= c1_uv_next;
            b_c1_u_reg  <= c1_u_next;
            b_c1_v_reg  <= c1_v_next;
            b_c2_uv_reg <= c2_uv_next;
            b_c2_u_reg  <= c2_u_next;
            b_c2_v_reg  <= c2_v_next;
        end
        if (b_valid_reg)
        begin
            pend_addr_reg          <= b_v_reg;
            pend_tag_reg           <= tag_new;
            fwd_u_reg              <= b_u_reg;
            fwd_v_reg              <= b_v_reg;
            fwd_tag_reg            <= tag_new;
            fifo_mem_reg[tail_reg] <= entry;
        end
    end

    `CBEP_ASSERT_ALWAYS(a_write_port_free, !(b_valid_reg && pend_valid_reg))
    `CBEP_ASSERT_IMPLIES(a_sweep_idle_pipe, clr_active_reg, !a_valid_reg && !b_valid_reg)
    `CBEP_ASSERT_NEXT(a_read_to_decide, a_valid_reg, b_valid_reg && !a_valid_reg)
    `CBEP_ASSERT_IMPLIES(a_queue_room, push, (count_reg < OUT_CNT_W'(OUT_DEPTH)) || pop)

endmodule

[tb/sv/capacity_budget_edge_partitioner_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for capacity_budget_edge_partitioner_core.
// Depends on cbep_pkg and the core RTL; a scoreboard class predicts each result.

import cbep_pkg::*;

localparam longint unsigned BYTES_PER_ID = 4;
localparam logic [PIDX_W-1:0] PART_LIMIT = 16'hFFFE;

typedef struct packed {
    logic [VID_W-1:0] u;
    logic [VID_W-1:0] v;
    logic [DEG_W-1:0] du;
    logic [DEG_W-1:0] dv;
    logic             last;
} edge_item_t;

class partition_scoreboard;
    logic [CAP_W-1:0]  capacity;
    logic [VTOT_W-1:0] vertex_total;
    logic [PIDX_W-1:0] part_tag [int unsigned];
    logic [PIDX_W-1:0] cur_part;
    longint unsigned   used_main;
    longint unsigned   used_aux;
    logic [CNT_W-1:0]  edges_in_part;
    logic [CNT_W-1:0]  edge_index;
    logic [CNT_W-1:0]  first_edge;
    logic [VCNT_W-1:0] verts_in_part;
    result_t           expected_q[$];
    int                errors;

    function new();
        clear_run();
        capacity = '0;
        vertex_total = '0;
        errors = 0;
    endfunction

    function void clear_run();
        part_tag.delete();
        cur_part = '0;
        used_main = 0;
        used_aux = 0;
        edges_in_part = '0;
        edge_index = '0;
        first_edge = '0;
        verts_in_part = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
        case (idx)
            REG_CAPACITY:     capacity = data;
            REG_VERTEX_TOTAL: vertex_total = data[VTOT_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [PIDX_W-1:0] tag_of(int unsigned id);
        if (part_tag.exists(id))
            return part_tag[id];
        return '0;
    endfunction

    function void join_vertex(int unsigned id, logic [PIDX_W-1:0] tag);
        if (tag_of(id) != tag)
        begin
            part_tag[id] = tag;
            if (verts_in_part != VCOUNT_MAX)
                verts_in_part++;
        end
    endfunction

    // Accepted edge transaction: advance the partition state, queue the result.
    function void note_edge(edge_item_t e);
        int unsigned       iu;
        int unsigned       iv;
        longint unsigned   du;
        longint unsigned   dv;
        longint unsigned   reserve;
        longint unsigned   avail1;
        longint unsigned   avail2;
        longint unsigned   cost_main;
        longint unsigned   cost_aux;
        logic [PIDX_W-1:0] tag;
        bit                mu;
        bit                mv;
        result_t           r;

        iu = e.u;
        iv = e.v;
        du = e.du;
        dv = e.dv;
        reserve = vertex_total;
        avail1 = (capacity > reserve * BYTES_PER_ID) ? capacity - reserve * BYTES_PER_ID : 0;
        avail2 = (capacity > reserve * BYTES_PER_ID * 2) ?
                 capacity - reserve * BYTES_PER_ID * 2 : 0;
        tag = cur_part + 1'b1;
        mu = (tag_of(iu) == tag);
        mv = (tag_of(iv) == tag);
        cost_main = ((mu ? 64'd0 : du + 4) + (mv ? 64'd0 : dv + 4) + 2) * BYTES_PER_ID + 1;
        cost_aux  = ((mu ? 64'd0 : du + 1) + (mv ? 64'd0 : dv + 1) + 2) * BYTES_PER_ID + 1;
        r = '0;

        if (used_main + cost_main < avail1 && used_aux + cost_aux < avail2)
        begin
            join_vertex(iu, tag);
            join_vertex(iv, tag);
            edges_in_part++;
            used_main += cost_main;
            used_aux += cost_aux;
        end
        else
        begin
            // new partition; once tags run out the index is held
            r.opened_new = 1'b1;
            if (cur_part < PART_LIMIT)
                cur_part++;
            else
                r.part_overflow = 1'b1;
            tag = cur_part + 1'b1;
            part_tag[iu] = tag;
            part_tag[iv] = tag;
            verts_in_part = (iu == iv) ? 1 : 2;
            edges_in_part = 1;
            first_edge = edge_index;
            used_main = (du + dv + 10) * BYTES_PER_ID + 1;
            used_aux = (du + dv + 4) * BYTES_PER_ID + 1;
        end

        r.part_index = cur_part;
        r.part_edges = edges_in_part;
        r.part_vertices = PVERT_W'(verts_in_part);
        r.part_first_edge = first_edge;
        r.run_done = e.last;
        expected_q.push_back(r);

        edge_index++;
        if (e.last)
            clear_run();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t result transaction with no edge pending: part_index %0d",
                     $time, got.part_index);
            return;
        end
        want = expected_q.pop_front();
        compare_field("part_index", want.part_index, got.part_index);
        compare_field("opened_new", want.opened_new, got.opened_new);
        compare_field("part_edges", want.part_edges, got.part_edges);
        compare_field("part_vertices", want.part_vertices, got.part_vertices);
        compare_field("part_first_edge", want.part_first_edge, got.part_first_edge);
        compare_field("run_done", want.run_done, got.run_done);
        compare_field("part_overflow", want.part_overflow, got.part_overflow);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module capacity_budget_edge_partitioner_core_tb;

    localparam int unsigned DEG_MAX = 1048576;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_CAPACITY;
    logic [CAP_W-1:0]     cfg_data     = '0;
    logic                 edge_valid   = 1'b0;
    logic                 edge_stall;
    logic [VID_W-1:0]     vertex_u     = '0;
    logic [VID_W-1:0]     vertex_v     = '0;
    logic [DEG_W-1:0]     degree_u     = '0;
    logic [DEG_W-1:0]     degree_v     = '0;
    logic                 last_edge    = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [PIDX_W-1:0]    part_index;
    logic                 opened_new;
    logic [CNT_W-1:0]     part_edges;
    logic [PVERT_W-1:0]   part_vertices;
    logic [CNT_W-1:0]     part_first_edge;
    logic                 run_done;
    logic                 part_overflow;

    partition_scoreboard sb = new();
    int burst_left = 0;
    int stall_left = 0;

    capacity_budget_edge_partitioner_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .edge_valid      (edge_valid),
        .edge_stall      (edge_stall),
        .vertex_u        (vertex_u),
        .vertex_v        (vertex_v),
        .degree_u        (degree_u),
        .degree_v        (degree_v),
        .last_edge       (last_edge),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .part_index      (part_index),
        .opened_new      (opened_new),
        .part_edges      (part_edges),
        .part_vertices   (part_vertices),
        .part_first_edge (part_first_edge),
        .run_done        (run_done),
        .part_overflow   (part_overflow)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver back-pressure: free runs, choppy spells and long stalls.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    result_stall <= 1'b0;
                    stall_left = $urandom_range(1, 40);
                end
                3:
                begin
                    result_stall <= 1'b1;
                    stall_left = $urandom_range(1, 12);
                end
                default:
                begin
                    result_stall <= 1'($urandom_range(0, 1));
                    stall_left = $urandom_range(1, 3);
                end
            endcase
        end
        else
            stall_left--;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (edge_valid && !edge_stall)
                sb.note_edge({vertex_u, vertex_v, degree_u, degree_v, last_edge});
            if (result_valid && !result_stall)
                sb.check_result({part_index, opened_new, part_edges, part_vertices,
                                 part_first_edge, run_done, part_overflow});
        end
    end

    task automatic write_registers(input logic [CAP_W-1:0] cap, input logic [VTOT_W-1:0] vtot);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_data <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_VERTEX_TOTAL;
        cfg_data <= CAP_W'(vtot);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sender works in bursts; a gap only opens at the start of a burst.
    task automatic send_edge(input edge_item_t e);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            edge_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_valid <= 1'b1;
        vertex_u <= e.u;
        vertex_v <= e.v;
        degree_u <= e.du;
        degree_v <= e.dv;
        last_edge <= e.last;
        do @(posedge clk); while (edge_stall);
    endtask

    task automatic drain();
        edge_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [DEG_W-1:0] pick_degree();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return DEG_W'($urandom_range(0, 24));
        if (r < 19)
            return DEG_W'($urandom_range(0, DEG_MAX));
        return $urandom_range(0, 1) ? DEG_W'(DEG_MAX) : '0;
    endfunction

    // Mostly ids from a small pool so that endpoints recur within a partition.
    function automatic edge_item_t pool_edge(int unsigned base, int unsigned span);
        edge_item_t e;
        e.u = ($urandom_range(0, 9) == 0) ? VID_W'($urandom) : VID_W'(base + $urandom_range(0, span - 1));
        e.v = ($urandom_range(0, 9) == 0) ? VID_W'($urandom) : VID_W'(base + $urandom_range(0, span - 1));
        e.du = pick_degree();
        e.dv = pick_degree();
        e.last = 1'b0;
        return e;
    endfunction

    initial
    begin
        logic [CAP_W-1:0]  cap;
        logic [VTOT_W-1:0] vtot;
        int unsigned       base;
        int unsigned       span;
        edge_item_t        e;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero budget: the very first edge leaves partition 0 empty
        write_registers('0, '0);
        send_edge({20'h00000, 20'hFFFFF, 21'h000000, 21'h000000, 1'b0});
        drain();

        write_registers(40'd2000, 21'd100);
        send_edge({20'h00005, 20'h00006, 21'h000003, 21'h000003, 1'b0});
        send_edge({20'h00006, 20'h00005, 21'h000000, 21'h000000, 1'b0});
        send_edge({20'h00007, 20'h00007, 21'h000002, 21'h000002, 1'b0});
        send_edge({20'h00000, 20'hFFFFF, 21'h100000, 21'h100000, 1'b0});
        send_edge({20'h00008, 20'h00009, 21'h100000, 21'h100000, 1'b0});
        send_edge({20'h0000A, 20'h0000B, 21'h000000, 21'h000000, 1'b0});
        send_edge({20'd500, 20'd70000, 21'h000000, 21'h000001, 1'b0});
        send_edge({20'h0000C, 20'h0000C, 21'h100000, 21'h000000, 1'b0});
        send_edge({20'hAAAAA, 20'h55555, 21'h0AAAAA, 21'h155555, 1'b0});
        send_edge({20'h55555, 20'hAAAAA, 21'h000000, 21'h000000, 1'b0});
        send_edge({20'hAAAAA, 20'h55555, 21'h000001, 21'h000001, 1'b0});
        send_edge({20'h0000D, 20'h0000E, 21'h000005, 21'h000005, 1'b0});
        send_edge({20'h0000D, 20'h0000F, 21'h000005, 21'h000005, 1'b0});
        drain();

        write_registers(40'hFF_FFFF_FFFF, 21'h100000);
        send_edge({20'hFFFFF, 20'h00000, 21'h100000, 21'h100000, 1'b0});
        send_edge({20'h00001, 20'h00002, 21'h100000, 21'h100000, 1'b0});
        drain();

        // reserve exceeds capacity, both budgets clamp to zero; run ends here
        write_registers(40'd1000, 21'h100000);
        send_edge({20'h00003, 20'h00004, 21'h000007, 21'h000007, 1'b0});
        send_edge({20'h00003, 20'h00004, 21'h000007, 21'h000007, 1'b1});
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin cap = 40'd2000; vtot = 21'd100; end
                1: begin cap = 40'd6000; vtot = 21'd0; end
                2: begin cap = 40'hFF_FFFF_FFFF; vtot = 21'd0; end
                3: begin cap = 40'hFF_FFFF_FFFF; vtot = 21'h100000; end
                4: begin cap = 40'd1000; vtot = 21'h100000; end
                5: begin cap = 40'd1500; vtot = 21'd300; end
                default:
                begin
                    cap = CAP_W'($urandom_range(200, 30000));
                    vtot = VTOT_W'($urandom_range(0, 2000));
                end
            endcase
            drain();
            write_registers(cap, vtot);
            base = $urandom;
            span = $urandom_range(4, 200);
            for (int n = 0; n < 230; n++)
            begin
                if (n == 115)
                    drain();
                send_edge(pool_edge(base, span));
            end
        end

        // every edge opens a partition until the tag range runs out
        drain();
        write_registers('0, '0);
        base = $urandom;
        for (int n = 0; n < 65540; n++)
            send_edge(pool_edge(base, 32));
        drain();

        // held tag: marks left from earlier partitions still count as members
        write_registers(40'd3000, '0);
        for (int n = 0; n < 40; n++)
        begin
            e = pool_edge(base, 32);
            e.last = (n == 39);
            send_edge(e);
        end
        drain();
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cbep_pkg.sv
hw/rtl/cbep_ram.sv
hw/rtl/capacity_budget_edge_partitioner_core.sv
tb/sv/capacity_budget_edge_partitioner_core_tb.sv
